[design/kmsh_pkg.sv]
// Shared types, constants, keymap tables and the microcode program of the key matrix
// scanner that builds HID boot keyboard reports.
// No dependencies; the top level and the sequencer refer to it by scoped names.
package kmsh_pkg;

  // Matrix and report geometry.
  localparam int ROWS  = 6;
  localparam int COLS  = 8;
  localparam int SLOTS = 6;

  typedef logic [2:0] row_t;
  typedef logic [2:0] col_t;
  typedef logic [2:0] cnt_t;
  typedef logic [2:0] step_t;

  localparam row_t ROW_END   = row_t'(ROWS);
  localparam row_t LAST_ROW  = row_t'(ROWS - 1);
  localparam col_t LAST_COL  = col_t'(COLS - 1);
  localparam cnt_t SLOT_FULL = cnt_t'(SLOTS);

  // Special keys and masks.
  localparam row_t SHIFT_ROW      = 3'd5;
  localparam col_t SHIFT_COL      = 3'd2;
  localparam logic [7:0] SHIFT_MOD = 8'h22;
  localparam row_t MENU_ROW       = 3'd0;
  localparam col_t MENU_COL       = 3'd6;
  localparam row_t R_ROW          = 3'd2;
  localparam col_t R_COL          = 3'd6;
  localparam col_t FIRST_MENU_COL = 3'd5;
  localparam int   JOY_BITS       = 5;

  // HID usage codes, unshifted map first, then shifted map.
  localparam logic [7:0] KEYMAP [2][ROWS][COLS] = '{
    '{
      '{8'h28, 8'h50, 8'h52, 8'h4F, 8'h51, 8'h3E, 8'h3B, 8'h00},
      '{8'h05, 8'h0B, 8'h19, 8'h1C, 8'h23, 8'h0A, 8'h17, 8'h22},
      '{8'h11, 8'h0D, 8'h06, 8'h18, 8'h24, 8'h09, 8'h15, 8'h21},
      '{8'h10, 8'h0E, 8'h1B, 8'h0C, 8'h25, 8'h07, 8'h08, 8'h20},
      '{8'h37, 8'h0F, 8'h1D, 8'h12, 8'h26, 8'h16, 8'h1A, 8'h1F},
      '{8'h2C, 8'h28, 8'h00, 8'h13, 8'h27, 8'h04, 8'h14, 8'h1E}
    },
    '{
      '{8'h28, 8'h50, 8'h52, 8'h4F, 8'h51, 8'h3C, 8'h3F, 8'h00},
      '{8'h05, 8'h0B, 8'h19, 8'h1C, 8'h23, 8'h0A, 8'h17, 8'h22},
      '{8'h11, 8'h0D, 8'h06, 8'h18, 8'h24, 8'h09, 8'h15, 8'h21},
      '{8'h10, 8'h0E, 8'h1B, 8'h0C, 8'h25, 8'h07, 8'h08, 8'h20},
      '{8'h37, 8'h0F, 8'h1D, 8'h12, 8'h26, 8'h16, 8'h1A, 8'h1F},
      '{8'h2C, 8'h28, 8'h00, 8'h13, 8'h27, 8'h04, 8'h14, 8'h1E}
    }
  };

  // Datapath actions selected by the control word.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_IDLE,
    ACT_STORE,
    ACT_LOAD,
    ACT_SEEK,
    ACT_WALK,
    ACT_EMIT
  } act_t;

  // Jump conditions tested by the sequencer.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_BEAT,
    COND_IS_REPORT,
    COND_SEEKING,
    COND_WALK_MORE,
    COND_OUT_BUSY
  } cond_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic no_beat;
    logic is_report;
    logic seeking;
    logic walk_more;
    logic out_busy;
  } flags_t;

  // One control word: action, jump condition, jump target, fall-through step.
  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t jump;
    step_t next;
  } ucode_t;

  // Program addresses.
  localparam step_t STEP_IDLE     = 3'd0;
  localparam step_t STEP_DISPATCH = 3'd1;
  localparam step_t STEP_STORE    = 3'd2;
  localparam step_t STEP_LOAD     = 3'd3;
  localparam step_t STEP_SEEK     = 3'd4;
  localparam step_t STEP_WALK     = 3'd5;
  localparam step_t STEP_EMIT     = 3'd6;

  // Control store.
  function automatic ucode_t ucode(step_t s);
    ucode_t w;
    w = '{act: ACT_NONE, cond: COND_NEVER, jump: STEP_IDLE, next: STEP_IDLE};
    unique case (s)
      STEP_IDLE:
        w = '{act: ACT_IDLE, cond: COND_NO_BEAT, jump: STEP_IDLE, next: STEP_DISPATCH};
      STEP_DISPATCH:
        w = '{act: ACT_NONE, cond: COND_IS_REPORT, jump: STEP_LOAD, next: STEP_STORE};
      STEP_STORE:
        w = '{act: ACT_STORE, cond: COND_NEVER, jump: STEP_IDLE, next: STEP_EMIT};
      STEP_LOAD:
        w = '{act: ACT_LOAD, cond: COND_NEVER, jump: STEP_IDLE, next: STEP_SEEK};
      STEP_SEEK:
        w = '{act: ACT_SEEK, cond: COND_SEEKING, jump: STEP_SEEK, next: STEP_WALK};
      STEP_WALK:
        w = '{act: ACT_WALK, cond: COND_WALK_MORE, jump: STEP_WALK, next: STEP_EMIT};
      STEP_EMIT:
        w = '{act: ACT_EMIT, cond: COND_OUT_BUSY, jump: STEP_EMIT, next: STEP_IDLE};
      default:
        w = '{act: ACT_NONE, cond: COND_NEVER, jump: STEP_IDLE, next: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

[design/kmsh_req_if.sv]
// Input channel of the key matrix scanner: valid/ready handshake with one scan or
// report request per beat. Depends on nothing.
interface kmsh_req_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] column_bits;
  logic [7:0] modifier_in;
  logic [7:0] slot0_in;
  logic [7:0] slot1_in;
  logic [7:0] slot2_in;
  logic [7:0] slot3_in;
  logic [7:0] slot4_in;
  logic [7:0] slot5_in;

  modport source (
    output valid, opcode, column_bits, modifier_in,
    output slot0_in, slot1_in, slot2_in, slot3_in, slot4_in, slot5_in,
    input  ready
  );

  modport sink (
    input  valid, opcode, column_bits, modifier_in,
    input  slot0_in, slot1_in, slot2_in, slot3_in, slot4_in, slot5_in,
    output ready
  );
endinterface

[design/kmsh_rsp_if.sv]
// Output channel of the key matrix scanner: valid/ready handshake with one report
// and status result per beat. Depends on nothing.
interface kmsh_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] modifier_out;
  logic [7:0] slot0_out;
  logic [7:0] slot1_out;
  logic [7:0] slot2_out;
  logic [7:0] slot3_out;
  logic [7:0] slot4_out;
  logic [7:0] slot5_out;
  logic       boot_request;
  logic [4:0] joystick_bits;
  logic [2:0] drive_row;

  modport source (
    output valid, modifier_out,
    output slot0_out, slot1_out, slot2_out, slot3_out, slot4_out, slot5_out,
    output boot_request, joystick_bits, drive_row,
    input  ready
  );

  modport sink (
    input  valid, modifier_out,
    input  slot0_out, slot1_out, slot2_out, slot3_out, slot4_out, slot5_out,
    input  boot_request, joystick_bits, drive_row,
    output ready
  );
endinterface

[design/key_matrix_scan_to_hid_report_top.sv]
// Key matrix scanner and HID boot report builder, top level and datapath.
// Scan beat: dispatch, store of the captured row into the matrix, then emit. Report beat:
// dispatch, load, the slot search, the walk over up to 43 matrix keys (one per cycle,
// ending early once all slots are full) and emit; a stalled result holds the emit step.
// Synchronous reset clears the stored matrix rows, the driven row and the output valid.
// Depends on kmsh_pkg, kmsh_req_if, kmsh_rsp_if and kmsh_useq.
module key_matrix_scan_to_hid_report_top (
  input  logic              clk,
  input  logic              rst,
  kmsh_req_if.sink          req,
  kmsh_rsp_if.source        rsp
);

  kmsh_pkg::act_t   act;
  kmsh_pkg::flags_t flags;

  // Matrix state.
  logic [7:0]       row_pressed [kmsh_pkg::ROWS];
  kmsh_pkg::row_t   scan_row;

  // Working registers of one item.
  logic             op_report;
  logic [7:0]       col_cap;
  logic [7:0]       mod;
  logic [7:0]       slot [kmsh_pkg::SLOTS];
  kmsh_pkg::cnt_t   used;
  kmsh_pkg::row_t   r;
  kmsh_pkg::col_t   c;
  logic             map_sel;

  // Output register.
  logic             rsp_valid;
  logic [7:0]       mod_out;
  logic [7:0]       slot_out [kmsh_pkg::SLOTS];
  logic             boot_out;
  logic [kmsh_pkg::JOY_BITS-1:0] joy_out;
  kmsh_pkg::row_t   drive_out;

  logic             beat;
  logic             out_busy;
  logic [7:0]       slot_at_used;
  logic [7:0]       key_code;
  logic             key_hit;
  kmsh_pkg::cnt_t   used_inc;
  logic             last_pos;

  kmsh_useq u_useq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .act   (act)
  );

  // Handshakes.
  assign req.ready = (act == kmsh_pkg::ACT_IDLE);
  assign beat      = req.valid && req.ready;
  assign out_busy  = rsp_valid && !rsp.ready;

  // Slot at the fill position, empty once all slots are used.
  always_comb begin
    slot_at_used = 8'h00;
    if (used != kmsh_pkg::SLOT_FULL) begin
      slot_at_used = slot[used];
    end
  end

  // Key at the walk position and whether it fills a slot.
  assign key_code = kmsh_pkg::KEYMAP[map_sel][r][c];
  assign key_hit  = (used != kmsh_pkg::SLOT_FULL) && row_pressed[r][c] && (key_code != 8'h00);
  assign used_inc = used + 3'd1;
  assign last_pos = (r == kmsh_pkg::LAST_ROW) && (c == kmsh_pkg::LAST_COL);

  // Status flags for the sequencer.
  always_comb begin
    flags.no_beat   = !beat;
    flags.is_report = op_report;
    flags.seeking   = (slot_at_used != 8'h00);
    flags.walk_more = !last_pos && (used != kmsh_pkg::SLOT_FULL) &&
                      !(key_hit && (used_inc == kmsh_pkg::SLOT_FULL));
    flags.out_busy  = out_busy;
  end

  // Datapath driven by the current action.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row  <= '0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < kmsh_pkg::ROWS; i++) begin
        row_pressed[i] <= 8'h00;
      end
    end else begin
      // Result valid is set by an emit step with a free output and cleared when taken.
      if (act == kmsh_pkg::ACT_EMIT && !out_busy) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (act)
        kmsh_pkg::ACT_IDLE: begin
          if (beat) begin
            op_report <= req.opcode;
            col_cap   <= req.column_bits;
            mod       <= req.modifier_in;
            slot[0]   <= req.slot0_in;
            slot[1]   <= req.slot1_in;
            slot[2]   <= req.slot2_in;
            slot[3]   <= req.slot3_in;
            slot[4]   <= req.slot4_in;
            slot[5]   <= req.slot5_in;
          end
        end
        kmsh_pkg::ACT_STORE: begin
          if (scan_row < kmsh_pkg::ROW_END) begin
            row_pressed[scan_row] <= col_cap;
          end
          scan_row <= (scan_row >= kmsh_pkg::LAST_ROW) ? 3'd0 : scan_row + 3'd1;
        end
        kmsh_pkg::ACT_LOAD: begin
          used    <= '0;
          r       <= '0;
          c       <= kmsh_pkg::FIRST_MENU_COL;
          map_sel <= row_pressed[kmsh_pkg::SHIFT_ROW][kmsh_pkg::SHIFT_COL];
          if (row_pressed[kmsh_pkg::SHIFT_ROW][kmsh_pkg::SHIFT_COL]) begin
            mod <= mod | kmsh_pkg::SHIFT_MOD;
          end
        end
        kmsh_pkg::ACT_SEEK: begin
          if (flags.seeking) begin
            used <= used_inc;
          end
        end
        kmsh_pkg::ACT_WALK: begin
          if (key_hit) begin
            slot[used] <= key_code;
            used       <= used_inc;
          end
          if (c == kmsh_pkg::LAST_COL) begin
            c <= '0;
            r <= r + 3'd1;
          end else begin
            c <= c + 3'd1;
          end
        end
        kmsh_pkg::ACT_EMIT: begin
          if (!out_busy) begin
            mod_out   <= op_report ? mod : 8'h00;
            for (int i = 0; i < kmsh_pkg::SLOTS; i++) begin
              slot_out[i] <= op_report ? slot[i] : 8'h00;
            end
            boot_out  <= row_pressed[kmsh_pkg::MENU_ROW][kmsh_pkg::MENU_COL] &&
                         row_pressed[kmsh_pkg::R_ROW][kmsh_pkg::R_COL];
            joy_out   <= row_pressed[0][kmsh_pkg::JOY_BITS-1:0];
            drive_out <= scan_row;
          end
        end
        kmsh_pkg::ACT_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Result channel.
  assign rsp.valid         = rsp_valid;
  assign rsp.modifier_out  = mod_out;
  assign rsp.slot0_out     = slot_out[0];
  assign rsp.slot1_out     = slot_out[1];
  assign rsp.slot2_out     = slot_out[2];
  assign rsp.slot3_out     = slot_out[3];
  assign rsp.slot4_out     = slot_out[4];
  assign rsp.slot5_out     = slot_out[5];
  assign rsp.boot_request  = boot_out;
  assign rsp.joystick_bits = joy_out;
  assign rsp.drive_row     = drive_out;

endmodule

[design/kmsh_useq.sv]
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on kmsh_pkg for the control word, action, condition and flag types.
module kmsh_useq (
  input  logic              clk,
  input  logic              rst,
  input  kmsh_pkg::flags_t  flags,
  output kmsh_pkg::act_t    act
);

  kmsh_pkg::step_t  step;
  kmsh_pkg::step_t  step_next;
  kmsh_pkg::ucode_t cw;
  logic             taken;

  // Fetch the control word of the current step.
  assign cw  = kmsh_pkg::ucode(step);
  assign act = cw.act;

  // Select the jump condition.
  always_comb begin
    unique case (cw.cond)
      kmsh_pkg::COND_NEVER:     taken = 1'b0;
      kmsh_pkg::COND_NO_BEAT:   taken = flags.no_beat;
      kmsh_pkg::COND_IS_REPORT: taken = flags.is_report;
      kmsh_pkg::COND_SEEKING:   taken = flags.seeking;
      kmsh_pkg::COND_WALK_MORE: taken = flags.walk_more;
      kmsh_pkg::COND_OUT_BUSY:  taken = flags.out_busy;
      default:                  taken = 1'b0;
    endcase
  end

  // Next step: jump target when the condition holds, else fall through.
  always_comb begin
    step_next = taken ? cw.jump : cw.next;
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= kmsh_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

[design/kmsh_check.sv]
// Port-level checker for the key matrix scanner and the bind that attaches it to the
// top level. Depends on key_matrix_scan_to_hid_report_top and its channel interfaces.
module kmsh_check (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] modifier_out,
  input logic [7:0] slot0_out,
  input logic [7:0] slot1_out,
  input logic [7:0] slot2_out,
  input logic [7:0] slot3_out,
  input logic [7:0] slot4_out,
  input logic [7:0] slot5_out,
  input logic       boot_request,
  input logic [4:0] joystick_bits,
  input logic [2:0] drive_row
);

  // A stalled result beat stays and holds its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid &&
      $stable({modifier_out, slot0_out, slot1_out, slot2_out, slot3_out, slot4_out,
               slot5_out, boot_request, joystick_bits, drive_row}))
    else $error("result beat changed while stalled");

  // Reset leaves no result pending.
  a_rst_clear: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // The reported driven row is always a real matrix row.
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> drive_row < 3'd6)
    else $error("driven row out of range");

  // A result cannot appear in the cycle right after an accepted request beat.
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !$rose(rsp_valid))
    else $error("result appeared before the item was processed");

endmodule

bind key_matrix_scan_to_hid_report_top kmsh_check u_kmsh_check (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .modifier_out  (rsp.modifier_out),
  .slot0_out     (rsp.slot0_out),
  .slot1_out     (rsp.slot1_out),
  .slot2_out     (rsp.slot2_out),
  .slot3_out     (rsp.slot3_out),
  .slot4_out     (rsp.slot4_out),
  .slot5_out     (rsp.slot5_out),
  .boot_request  (rsp.boot_request),
  .joystick_bits (rsp.joystick_bits),
  .drive_row     (rsp.drive_row)
);

[test/kmsh_tb_pkg.sv]
`timescale 1ns / 1ps
// Beat codes and vector types shared by the key matrix scanner testbench files.
// Depends on kmsh_pkg for the matrix and report geometry.
package kmsh_tb_pkg;

  // Request opcodes of the input channel.
  typedef enum logic {
    OP_SCAN   = 1'b0,
    OP_REPORT = 1'b1
  } op_t;

  // Six keycode slots, slot 0 in the low byte.
  typedef logic [kmsh_pkg::SLOTS-1:0][7:0] slot_vec_t;

  // One full matrix frame, row 0 in the low byte.
  typedef logic [kmsh_pkg::ROWS-1:0][7:0] frame_t;

endpackage

[test/kmsh_report_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the key matrix scanner: tracks the stored matrix, predicts every
// result beat and compares it field by field. Depends on kmsh_pkg, kmsh_tb_pkg and the
// two channel interfaces.
module kmsh_report_checker (
  input  logic clk,
  input  logic rst,
  kmsh_req_if  req,
  kmsh_rsp_if  rsp,
  output int   mismatches,
  output int   outstanding,
  output int   scans_seen,
  output int   reports_seen
);

  localparam int ROWS  = kmsh_pkg::ROWS;
  localparam int COLS  = kmsh_pkg::COLS;
  localparam int SLOTS = kmsh_pkg::SLOTS;

  // Positions of the keys with a special meaning.
  localparam int         SHIFT_KEY_ROW = 5;
  localparam int         SHIFT_KEY_COL = 2;
  localparam logic [7:0] SHIFT_BITS    = 8'h22;
  localparam int         MENU_KEY_ROW  = 0;
  localparam int         MENU_KEY_COL  = 6;
  localparam int         R_KEY_ROW     = 2;
  localparam int         R_KEY_COL     = 6;
  localparam int         ROW0_START    = 5;

  // HID usage codes, plain map then shifted map.
  localparam logic [7:0] USAGE_MAP [2][6][8] = '{
    '{
      '{8'h28, 8'h50, 8'h52, 8'h4F, 8'h51, 8'h3E, 8'h3B, 8'h00},
      '{8'h05, 8'h0B, 8'h19, 8'h1C, 8'h23, 8'h0A, 8'h17, 8'h22},
      '{8'h11, 8'h0D, 8'h06, 8'h18, 8'h24, 8'h09, 8'h15, 8'h21},
      '{8'h10, 8'h0E, 8'h1B, 8'h0C, 8'h25, 8'h07, 8'h08, 8'h20},
      '{8'h37, 8'h0F, 8'h1D, 8'h12, 8'h26, 8'h16, 8'h1A, 8'h1F},
      '{8'h2C, 8'h28, 8'h00, 8'h13, 8'h27, 8'h04, 8'h14, 8'h1E}
    },
    '{
      '{8'h28, 8'h50, 8'h52, 8'h4F, 8'h51, 8'h3C, 8'h3F, 8'h00},
      '{8'h05, 8'h0B, 8'h19, 8'h1C, 8'h23, 8'h0A, 8'h17, 8'h22},
      '{8'h11, 8'h0D, 8'h06, 8'h18, 8'h24, 8'h09, 8'h15, 8'h21},
      '{8'h10, 8'h0E, 8'h1B, 8'h0C, 8'h25, 8'h07, 8'h08, 8'h20},
      '{8'h37, 8'h0F, 8'h1D, 8'h12, 8'h26, 8'h16, 8'h1A, 8'h1F},
      '{8'h2C, 8'h28, 8'h00, 8'h13, 8'h27, 8'h04, 8'h14, 8'h1E}
    }
  };

  typedef struct packed {
    logic [7:0]             modifier;
    kmsh_tb_pkg::slot_vec_t slots;
    logic                   boot;
    logic [4:0]             joy;
    logic [2:0]             row;
  } hid_reply_t;

  logic [7:0] matrix_rows [ROWS];
  logic [2:0] drive_ptr;
  hid_reply_t replies_due [$];
  int         err_count = 0;
  int         scan_count = 0;
  int         report_count = 0;

  // Applies one request to the matrix copy and returns the reply it should produce.
  function automatic hid_reply_t reply_for_beat(logic op, logic [7:0] cols,
                                                logic [7:0] mod,
                                                kmsh_tb_pkg::slot_vec_t slots_in);
    hid_reply_t r;
    int         fill;
    int         first_col;
    logic       shifted;
    logic [7:0] code;
    r = '0;
    if (op == kmsh_tb_pkg::OP_SCAN) begin
      if (int'(drive_ptr) < ROWS) matrix_rows[drive_ptr] = cols;
      drive_ptr = (int'(drive_ptr) + 1 >= ROWS) ? 3'd0 : drive_ptr + 3'd1;
    end else begin
      shifted = matrix_rows[SHIFT_KEY_ROW][SHIFT_KEY_COL];
      r.modifier = shifted ? (mod | SHIFT_BITS) : mod;
      r.slots = slots_in;
      fill = 0;
      while (fill < SLOTS && r.slots[fill] != 8'h00) fill++;
      // Walk the pressed keys in scan order into the slots from the first empty one on.
      for (int row = 0; row < ROWS; row++) begin
        first_col = (row == 0) ? ROW0_START : 0;
        for (int col = first_col; col < COLS; col++) begin
          code = USAGE_MAP[shifted][row][col];
          if (fill < SLOTS && matrix_rows[row][col] && code != 8'h00) begin
            r.slots[fill] = code;
            fill++;
          end
        end
      end
    end
    r.boot = matrix_rows[MENU_KEY_ROW][MENU_KEY_COL] & matrix_rows[R_KEY_ROW][R_KEY_COL];
    r.joy = matrix_rows[0][4:0];
    r.row = drive_ptr;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_count++;
    end
  endtask

  // Watch both channels: compare each result beat, then predict each request beat.
  always @(posedge clk) begin
    hid_reply_t             want;
    kmsh_tb_pkg::slot_vec_t got_slots;
    if (rst) begin
      for (int k = 0; k < ROWS; k++) matrix_rows[k] = 8'h00;
      drive_ptr = 3'd0;
      replies_due.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (replies_due.size() == 0) begin
          $display("%0t: result beat with no request pending, expected none, actual %0h",
                   $time, rsp.modifier_out);
          err_count++;
        end else begin
          want = replies_due.pop_front();
          got_slots = {rsp.slot5_out, rsp.slot4_out, rsp.slot3_out,
                       rsp.slot2_out, rsp.slot1_out, rsp.slot0_out};
          compare_field("modifier_out", want.modifier, rsp.modifier_out);
          for (int k = 0; k < SLOTS; k++)
            compare_field($sformatf("slot%0d_out", k), want.slots[k], got_slots[k]);
          compare_field("boot_request", 8'(want.boot), 8'(rsp.boot_request));
          compare_field("joystick_bits", 8'(want.joy), 8'(rsp.joystick_bits));
          compare_field("drive_row", 8'(want.row), 8'(rsp.drive_row));
        end
      end
      if (req.valid && req.ready) begin
        replies_due.push_back(reply_for_beat(req.opcode, req.column_bits, req.modifier_in,
                              {req.slot5_in, req.slot4_in, req.slot3_in,
                               req.slot2_in, req.slot1_in, req.slot0_in}));
        if (req.opcode == kmsh_tb_pkg::OP_SCAN) scan_count++;
        else report_count++;
      end
    end
    mismatches   <= err_count;
    outstanding  <= replies_due.size();
    scans_seen   <= scan_count;
    reports_seen <= report_count;
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Top of the key matrix scanner testbench: clock, reset, request and response drivers,
// directed and random beats, watchdog and verdict. Depends on kmsh_tb_pkg, the channel
// interfaces, the block and kmsh_report_checker.
module tb;

  localparam int RANDOM_BEATS = 1025;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 64;
  localparam int IDLE_PCT     = 17;

  logic clk;
  logic rst;
  logic calm = 1'b0;
  logic hold_req = 1'b0;
  int   mismatches;
  int   outstanding;
  int   scans_seen;
  int   reports_seen;

  kmsh_req_if req_ch ();
  kmsh_rsp_if rsp_ch ();

  key_matrix_scan_to_hid_report_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  kmsh_report_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .scans_seen   (scans_seen),
    .reports_seen (reports_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offers one request beat, after random idle cycles, and returns once it is taken.
  task automatic send_beat(input kmsh_tb_pkg::op_t op, input logic [7:0] cols,
                           input logic [7:0] mod, input kmsh_tb_pkg::slot_vec_t slots);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.opcode      <= op;
    req_ch.column_bits <= cols;
    req_ch.modifier_in <= mod;
    req_ch.slot0_in    <= slots[0];
    req_ch.slot1_in    <= slots[1];
    req_ch.slot2_in    <= slots[2];
    req_ch.slot3_in    <= slots[3];
    req_ch.slot4_in    <= slots[4];
    req_ch.slot5_in    <= slots[5];
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Scans all six rows in order; the driven row is at row 0 whenever this is called.
  task automatic scan_frame(input kmsh_tb_pkg::frame_t rows);
    for (int r = 0; r < kmsh_pkg::ROWS; r++)
      send_beat(kmsh_tb_pkg::OP_SCAN, rows[r], 8'($urandom),
                kmsh_tb_pkg::slot_vec_t'({$urandom, $urandom}));
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Mostly sparse rows so that reports do not always saturate the six slots.
  function automatic logic [7:0] pick_columns();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return 8'h00;
    if (sel < 6) return 8'h01 << $urandom_range(0, 7);
    if (sel < 7) return (8'h01 << $urandom_range(0, 7)) | (8'h01 << $urandom_range(0, 7));
    if (sel < 9) return 8'($urandom);
    return 8'hFF;
  endfunction

  // A run of occupied slots, then, unless the run fills all six, an empty one and a random mix.
  function automatic kmsh_tb_pkg::slot_vec_t pick_slots();
    kmsh_tb_pkg::slot_vec_t s;
    int unsigned            lead;
    lead = $urandom_range(0, kmsh_pkg::SLOTS);
    for (int k = 0; k < kmsh_pkg::SLOTS; k++) begin
      if (k < lead) s[k] = 8'($urandom_range(1, 255));
      else if (k == lead) s[k] = 8'h00;
      else s[k] = ($urandom_range(0, 1) == 1) ? 8'h00 : 8'($urandom);
    end
    return s;
  endfunction

  function automatic logic [7:0] pick_modifier();
    int unsigned sel;
    sel = $urandom_range(0, 5);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // Response side: random back-pressure, one long hold-off on request.
  initial begin
    bit held;
    held = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  // Ends the run when no beat moves on either channel for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: watchdog, no beat accepted for %0d cycles", $time, STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Stimulus: reset, directed beats, random beats, drain and verdict.
  initial begin
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.opcode      <= kmsh_tb_pkg::OP_SCAN;
    req_ch.column_bits <= 8'h00;
    req_ch.modifier_in <= 8'h00;
    req_ch.slot0_in    <= 8'h00;
    req_ch.slot1_in    <= 8'h00;
    req_ch.slot2_in    <= 8'h00;
    req_ch.slot3_in    <= 8'h00;
    req_ch.slot4_in    <= 8'h00;
    req_ch.slot5_in    <= 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Report from the cleared matrix.
    send_beat(kmsh_tb_pkg::OP_REPORT, 8'h00, 8'h00, '0);
    // Every key pressed: shifted map, shift bits, boot request, all slots filled.
    scan_frame({6{8'hFF}});
    send_beat(kmsh_tb_pkg::OP_REPORT, 8'h00, 8'h00, '0);
    // No free slot: slots pass through, modifier still gets the shift bits.
    send_beat(kmsh_tb_pkg::OP_REPORT, 8'hFF, 8'hFF, {6{8'hFF}});
    // Filling starts at the first empty slot and overwrites later codes.
    send_beat(kmsh_tb_pkg::OP_REPORT, 8'h00, 8'h81,
              {8'h66, 8'h00, 8'h44, 8'h33, 8'h00, 8'h11});
    // Menu and R together with all joystick bits; the empty map entry is skipped.
    scan_frame({8'h00, 8'h00, 8'h00, 8'h40, 8'h00, 8'hFF});
    send_beat(kmsh_tb_pkg::OP_REPORT, 8'h00, 8'h5A, '0);
    // Shift alone: it gives no keycode of its own.
    scan_frame({8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    send_beat(kmsh_tb_pkg::OP_REPORT, 8'h00, 8'h00, '0);
    send_beat(kmsh_tb_pkg::OP_REPORT, 8'h00, 8'h00,
              {8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06});

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == 150) hold_req <= 1'b1;
      if (n == 450) wait_drained();
      if (n == 600) calm <= 1'b1;
      if (n == 800) calm <= 1'b0;
      if ($urandom_range(0, 99) < 60)
        send_beat(kmsh_tb_pkg::OP_SCAN, pick_columns(), 8'($urandom),
                  kmsh_tb_pkg::slot_vec_t'({$urandom, $urandom}));
      else
        send_beat(kmsh_tb_pkg::OP_REPORT, 8'($urandom), pick_modifier(), pick_slots());
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d row scans and %0d report builds, with a long output stall,",
             scans_seen, reports_seen);
    $display("a full drain mid-run and a stretch with no idling on either side");
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
design/kmsh_pkg.sv
design/kmsh_req_if.sv
design/kmsh_rsp_if.sv
design/kmsh_useq.sv
design/key_matrix_scan_to_hid_report_top.sv
design/kmsh_check.sv
test/kmsh_tb_pkg.sv
test/kmsh_report_checker.sv
test/tb.sv
